FILE: hdl/tff_pkg.sv
package tff_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int MAG_W     = PROD_W - 1;
  localparam int DIV_STEPS = WORD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // 2^48 / d with d > 2^17: the first remainder is the numerator's top part.
  localparam logic [PROD_W-1:0] REM_INIT    = PROD_W'(1) << (3 * FRAC_W - WORD_W);
  localparam logic [MAG_W-1:0]  PIVOT_LIMIT = MAG_W'(1) << (3 * FRAC_W - WORD_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAMMA,
    S_MUL,
    S_PIVOT,
    S_DIV,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic gamma_en;
    logic mul_en;
    logic pivot_en;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  typedef struct packed {
    logic                     row_start;
    logic signed [WORD_W-1:0] sub_diag;
    logic signed [WORD_W-1:0] raw_diag;
    logic signed [WORD_W-1:0] diag_adjust;
    logic signed [WORD_W-1:0] super_diag;
  } item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] adjusted_diag;
    logic signed [WORD_W-1:0] gamma;
    logic signed [WORD_W-1:0] beta;
    logic                     zero_pivot;
    logic                     saturated;
  } result_t;

endpackage

FILE: hdl/tff_in_if.sv
interface tff_in_if;
  import tff_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     row_start;
  logic signed [WORD_W-1:0] sub_diag;
  logic signed [WORD_W-1:0] raw_diag;
  logic signed [WORD_W-1:0] diag_adjust;
  logic signed [WORD_W-1:0] super_diag;

  modport source (
    output valid, row_start, sub_diag, raw_diag, diag_adjust, super_diag,
    input  ready
  );

  modport sink (
    input  valid, row_start, sub_diag, raw_diag, diag_adjust, super_diag,
    output ready
  );
endinterface

FILE: hdl/tff_out_if.sv
interface tff_out_if;
  import tff_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] adjusted_diag;
  logic signed [WORD_W-1:0] gamma;
  logic signed [WORD_W-1:0] beta;
  logic                     zero_pivot;
  logic                     saturated;

  modport source (
    output valid, adjusted_diag, gamma, beta, zero_pivot, saturated,
    input  ready
  );

  modport sink (
    input  valid, adjusted_diag, gamma, beta, zero_pivot, saturated,
    output ready
  );
endinterface

FILE: hdl/tff_ctrl.sv
module tff_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tff_pkg::status_t status,
  output tff_pkg::cmd_t    cmd
);
  import tff_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic             div_last;

  assign div_last = (cnt == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_GAMMA;
      S_GAMMA:  state_next = S_MUL;
      S_MUL:    state_next = S_PIVOT;
      S_PIVOT:  state_next = S_DIV;
      S_DIV:    if (div_last) state_next = S_FINISH;
      S_FINISH: if (status.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_GAMMA:  cmd.gamma_en = 1'b1;
      S_MUL:    cmd.mul_en   = 1'b1;
      S_PIVOT:  cmd.pivot_en = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_FINISH: cmd.finish   = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_PIVOT) |=> (state == S_DIV) && (cnt == '0))
    else $error("divide phase did not start cleanly");

endmodule

FILE: hdl/tff_datapath.sv
module tff_datapath (
  input  logic              clk,
  input  logic              rst,
  input  tff_pkg::cmd_t     cmd,
  output tff_pkg::status_t  status,
  input  tff_pkg::item_t    item,
  output tff_pkg::result_t  result,
  output logic              out_valid,
  input  logic              out_ready
);
  import tff_pkg::*;

  logic signed [WORD_W-1:0] last_beta;
  logic signed [WORD_W-1:0] last_super;

  logic signed [WORD_W-1:0] a_q;
  logic signed [WORD_W-1:0] b_q;
  logic                     first_q;
  logic                     bsat_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [WORD_W-1:0] g_q;
  logic                     gsat_q;
  logic signed [PROD_W-1:0] ag_q;
  logic                     piv_neg_q;
  logic                     piv_zero_q;
  logic [MAG_W-1:0]         div_mag;
  logic [PROD_W-1:0]        rem_q;
  logic [WORD_W-1:0]        quo_q;

  logic signed [WORD_W:0]   sum;
  logic signed [WORD_W-1:0] b_clip;
  logic                     b_ovf;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] g_shift;
  logic                     g_fits;
  logic signed [PROD_W-1:0] ag;
  logic signed [PROD_W-1:0] pivot;
  logic [PROD_W-1:0]        pivot_abs;
  logic [PROD_W-1:0]        rem_shift;
  logic                     rem_ge;
  logic signed [WORD_W-1:0] beta_val;
  logic                     beta_sat;
  logic                     zp_val;

  assign sum    = {item.raw_diag[WORD_W-1], item.raw_diag}
                + {item.diag_adjust[WORD_W-1], item.diag_adjust};
  assign b_ovf  = sum[WORD_W] != sum[WORD_W-1];
  assign b_clip = b_ovf ? (sum[WORD_W] ? WORD_MIN : WORD_MAX) : sum[WORD_W-1:0];
  assign prod   = last_super * last_beta;

  assign g_shift = prod_q >>> FRAC_W;
  assign g_fits  = (&g_shift[PROD_W-1:WORD_W-1]) || !(|g_shift[PROD_W-1:WORD_W-1]);

  assign ag = a_q * g_q;

  assign pivot     = {{(WORD_W-FRAC_W){b_q[WORD_W-1]}}, b_q, {FRAC_W{1'b0}}} - ag_q;
  assign pivot_abs = pivot[PROD_W-1] ? PROD_W'(-pivot) : PROD_W'(pivot);

  assign rem_shift = {rem_q[PROD_W-2:0], 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, div_mag};

  always_comb begin
    zp_val   = 1'b0;
    beta_sat = 1'b0;
    beta_val = piv_neg_q ? -$signed(quo_q) : $signed(quo_q);
    if (piv_zero_q) begin
      zp_val   = 1'b1;
      beta_sat = 1'b1;
      beta_val = WORD_MAX;
    end else if (div_mag < PIVOT_LIMIT) begin
      beta_sat = 1'b1;
      beta_val = piv_neg_q ? WORD_MIN : WORD_MAX;
    end else if (div_mag == PIVOT_LIMIT) begin
      beta_sat = !piv_neg_q;
      beta_val = piv_neg_q ? WORD_MIN : WORD_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_beta  <= '0;
      last_super <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        last_super <= item.super_diag;
      end
      if (cmd.finish) begin
        last_beta <= beta_val;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_q     <= item.sub_diag;
      b_q     <= b_clip;
      bsat_q  <= b_ovf;
      first_q <= item.row_start;
      prod_q  <= prod;
    end
    if (cmd.gamma_en) begin
      if (first_q) begin
        g_q    <= '0;
        gsat_q <= 1'b0;
      end else if (g_fits) begin
        g_q    <= g_shift[WORD_W-1:0];
        gsat_q <= 1'b0;
      end else begin
        g_q    <= g_shift[PROD_W-1] ? WORD_MIN : WORD_MAX;
        gsat_q <= 1'b1;
      end
    end
    if (cmd.mul_en) begin
      ag_q <= ag;
    end
    if (cmd.pivot_en) begin
      piv_neg_q  <= pivot[PROD_W-1];
      piv_zero_q <= (pivot == '0);
      div_mag    <= pivot_abs[MAG_W-1:0];
      rem_q      <= REM_INIT;
      quo_q      <= '0;
    end
    if (cmd.div_step) begin
      rem_q <= rem_ge ? (rem_shift - {1'b0, div_mag}) : rem_shift;
      quo_q <= {quo_q[WORD_W-2:0], rem_ge};
    end
    if (cmd.finish) begin
      result.adjusted_diag <= b_q;
      result.gamma         <= g_q;
      result.beta          <= beta_val;
      result.zero_pivot    <= zp_val;
      result.saturated     <= bsat_q | gsat_q | beta_sat;
    end
  end

  assign status.out_free = !out_valid || out_ready;

  a_beta_state: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.finish) |-> (last_beta == result.beta))
    else $error("stored beta differs from delivered beta");

  a_row_start_gamma: assert property (@(posedge clk) disable iff (rst)
    (cmd.gamma_en && first_q) |=> (g_q == '0) && !gsat_q)
    else $error("gamma not cleared at row start");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && (div_mag > PIVOT_LIMIT)) |-> (rem_q < {1'b0, div_mag}))
    else $error("divider remainder out of range");

  a_zero_pivot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.zero_pivot) |-> (result.saturated && result.beta == WORD_MAX))
    else $error("zero pivot result malformed");

endmodule

FILE: hdl/tridiagonal_forward_factor_core.sv
// Tridiagonal forward factor core (Thomas algorithm, forward sweep).
// items: one transaction per matrix element, rows back to back; row_start
//   marks the first element of each row. Operands are signed Q16.16.
// results: one transaction per item with adjusted_diag, gamma, beta and the
//   zero_pivot / saturated flags.
// The recurrence on beta forces items to run one at a time: a new item is
//   not taken until the last one is finished. Each runs a gamma multiply, an
//   a*gamma multiply, a pivot subtract, then a 32-step restoring divider
//   producing one quotient bit per cycle for 2^48 / pivot.
// A finished result sits in the output register; the next item is taken
//   while it waits. If the receiver stalls, the following result holds in
//   the divider until the output register is free, and items.ready stays low.
// Reset (rst, synchronous) clears the stored beta and super-diagonal to
//   zero, drops results.valid and returns the controller to idle.
module tridiagonal_forward_factor_core (
  input logic       clk,
  input logic       rst,
  tff_in_if.sink    items,
  tff_out_if.source results
);
  import tff_pkg::*;

  cmd_t    cmd;
  status_t status;
  item_t   item;
  result_t result;

  assign item.row_start   = items.row_start;
  assign item.sub_diag    = items.sub_diag;
  assign item.raw_diag    = items.raw_diag;
  assign item.diag_adjust = items.diag_adjust;
  assign item.super_diag  = items.super_diag;

  tff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tff_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .item      (item),
    .result    (result),
    .out_valid (results.valid),
    .out_ready (results.ready)
  );

  assign results.adjusted_diag = result.adjusted_diag;
  assign results.gamma         = result.gamma;
  assign results.beta          = result.beta;
  assign results.zero_pivot    = result.zero_pivot;
  assign results.saturated     = result.saturated;

endmodule

FILE: test/tff_factor_checker.sv
`timescale 1ns / 100ps

module tff_factor_checker (
  input  logic clk,
  input  logic rst,
  tff_in_if    items,
  tff_out_if   results,
  output int   pending,
  output int   fail_count
);
  import tff_pkg::*;

  longint  prev_beta  = 0;
  longint  prev_super = 0;
  result_t factor_q[$];
  result_t want;
  int      failures   = 0;

  function automatic longint clip_word(longint v, inout logic sat);
    if (v > longint'(WORD_MAX)) begin
      sat = 1'b1;
      return longint'(WORD_MAX);
    end
    if (v < longint'(WORD_MIN)) begin
      sat = 1'b1;
      return longint'(WORD_MIN);
    end
    return v;
  endfunction

  // One element of the forward sweep; updates the carried beta and super-diagonal.
  function automatic result_t factor_step(logic first, longint a, longint raw, longint adj,
                                          longint c);
    result_t r;
    longint  b;
    longint  g;
    longint  piv;
    longint  q;
    logic    sat;
    logic    zp;
    sat = 1'b0;
    zp  = 1'b0;
    b   = clip_word(raw + adj, sat);
    if (first) begin
      g = 0;
    end else begin
      g = clip_word((prev_super * prev_beta) >>> FRAC_W, sat);
    end
    // pivot in Q32.32, exact
    piv = (b <<< FRAC_W) - a * g;
    if (piv == 0) begin
      zp  = 1'b1;
      sat = 1'b1;
      q   = longint'(WORD_MAX);
    end else begin
      q = clip_word((longint'(1) <<< (3 * FRAC_W)) / piv, sat);
    end
    prev_beta       = q;
    prev_super      = c;
    r.adjusted_diag = WORD_W'(b);
    r.gamma         = WORD_W'(g);
    r.beta          = WORD_W'(q);
    r.zero_pivot    = zp;
    r.saturated     = sat;
    return r;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      prev_beta  = 0;
      prev_super = 0;
      factor_q.delete();
    end else begin
      if (results.valid && results.ready) begin
        if (factor_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          failures++;
        end else begin
          want = factor_q.pop_front();
          check_field("adjusted_diag", want.adjusted_diag, $signed(results.adjusted_diag));
          check_field("gamma", want.gamma, $signed(results.gamma));
          check_field("beta", want.beta, $signed(results.beta));
          check_field("zero_pivot", want.zero_pivot, results.zero_pivot);
          check_field("saturated", want.saturated, results.saturated);
        end
      end
      if (items.valid && items.ready) begin
        factor_q.push_back(factor_step(items.row_start,
                                       longint'($signed(items.sub_diag)),
                                       longint'($signed(items.raw_diag)),
                                       longint'($signed(items.diag_adjust)),
                                       longint'($signed(items.super_diag))));
      end
    end
    pending    = factor_q.size();
    fail_count = failures;
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tff_pkg::*;

  localparam int ITEM_TOTAL = 1050;
  localparam int ONE        = 32'h0001_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   expected_count;
  int   fail_count;
  int   sent       = 0;
  logic send_quiet = 1'b0;
  logic recv_quiet = 1'b0;

  tff_in_if  items_if();
  tff_out_if results_if();

  tridiagonal_forward_factor_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  tff_factor_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .items      (items_if),
    .results    (results_if),
    .pending    (expected_count),
    .fail_count (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_element(logic rs, logic signed [31:0] a, logic signed [31:0] raw,
                              logic signed [31:0] adj, logic signed [31:0] c);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      items_if.valid <= 1'b0;
    end
    @(negedge clk);
    items_if.valid       <= 1'b1;
    items_if.row_start   <= rs;
    items_if.sub_diag    <= a;
    items_if.raw_diag    <= raw;
    items_if.diag_adjust <= adj;
    items_if.super_diag  <= c;
    do @(posedge clk); while (!items_if.ready);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    items_if.valid <= 1'b0;
    while (expected_count != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return 32'sd0;
          3: return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  // mostly diagonally dominant rows with random content
  function automatic logic signed [31:0] pick_diag();
    logic signed [31:0] d;
    if ($urandom_range(0, 3) == 0) return pick_word();
    d = $urandom_range(2 * ONE, 16 * ONE);
    return $urandom_range(0, 1) ? -d : d;
  endfunction

  task automatic send_row();
    int   len;
    logic rs;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      rs = (i == 0);
      if ($urandom_range(0, 19) == 0) rs = 1'($urandom_range(0, 1));
      send_element(rs, pick_word(), pick_diag(), pick_word(), pick_word());
    end
  endtask

  // receiver
  initial begin
    int stall;
    results_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_quiet = ~recv_quiet;
      stall = recv_quiet ? 0 : $urandom_range(0, 6);
      repeat (stall) begin
        @(negedge clk);
        results_if.ready <= 1'b0;
      end
      @(negedge clk);
      results_if.ready <= 1'b1;
      do @(posedge clk); while (!results_if.valid);
    end
  end

  initial begin
    items_if.valid       = 1'b0;
    items_if.row_start   = 1'b0;
    items_if.sub_diag    = '0;
    items_if.raw_diag    = '0;
    items_if.diag_adjust = '0;
    items_if.super_diag  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no preceding element: state from reset
    send_element(1'b0, 32'sd12345, 2 * ONE, 0, ONE);
    send_element(1'b1, 0, ONE, 0, ONE);
    // exact cancellation: gamma = 1.0, a = 1.0, b = 1.0
    send_element(1'b0, ONE, ONE, 0, 0);
    send_element(1'b1, 0, 0, 0, WORD_MAX);
    // gamma clips high after a zero pivot
    send_element(1'b0, 0, ONE, 0, WORD_MIN);
    send_element(1'b1, 0, 0, 0, WORD_MIN);
    send_element(1'b0, ONE, 4 * ONE, 0, -ONE);
    send_element(1'b1, 0, WORD_MAX, WORD_MAX, 0);
    send_element(1'b1, 0, WORD_MIN, WORD_MIN, 0);
    send_element(1'b1, 0, 32'sd1, 0, 0);
    send_element(1'b1, 0, -32'sd1, 0, 0);
    send_element(1'b1, 0, 3 * ONE, 0, -ONE);
    send_element(1'b0, -ONE, 3 * ONE, 0, ONE);
    send_element(1'b0, WORD_MAX, WORD_MAX, 0, WORD_MAX);
    send_element(1'b0, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MIN);
    send_element(1'b0, WORD_MIN, WORD_MIN, 0, WORD_MAX);
    send_element(1'b1, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MAX);
    send_element(1'b0, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
    send_element(1'b0, 0, 0, 0, 0);
    send_element(1'b1, 32'sd7, -(5 * ONE), ONE, 32'sd3);
    send_element(1'b0, 32'sd7, -(5 * ONE), -ONE, 32'sd3);
    drain();

    while (sent < ITEM_TOTAL) begin
      if ($urandom_range(0, 7) == 0) send_quiet = ~send_quiet;
      send_row();
      if (sent >= ITEM_TOTAL / 2 && sent < ITEM_TOTAL / 2 + 8) drain();
    end
    @(negedge clk);
    items_if.valid <= 1'b0;

    while (expected_count != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/tff_pkg.sv
hdl/tff_in_if.sv
hdl/tff_out_if.sv
hdl/tff_ctrl.sv
hdl/tff_datapath.sv
hdl/tridiagonal_forward_factor_core.sv
test/tff_factor_checker.sv
test/testbench.sv
